### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh: assertion macros included by rpn_ctrl
// Clocked on clk; the first form is disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RPN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RPN_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RPN_ASSERT(lbl, prop, msg)
`define RPN_ASSERT_RST(lbl, prop, msg)
`endif
`endif

### rtl/rpn_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rpn_pkg: shared types and constants
// Request codes, controller/datapath command and status bundles, helpers.
// ---------------------------------------------------------------------------
package rpn_pkg;

  localparam int DATA_W = 32;
  localparam int DVD_W  = 48;
  localparam int FLAG_W = 5;

  typedef logic [2:0] req_t;
  localparam req_t REQ_PUSH = 3'd0;
  localparam req_t REQ_ADD  = 3'd1;
  localparam req_t REQ_SUB  = 3'd2;
  localparam req_t REQ_MUL  = 3'd3;
  localparam req_t REQ_DIV  = 3'd4;
  localparam req_t REQ_MOD  = 3'd5;
  localparam req_t REQ_PEEK = 3'd6;
  localparam req_t REQ_UNK  = 3'd7;

  typedef struct packed {
    logic start;
    logic pop;
    logic lat_b;
    logic lat_a;
    logic mul;
    logic div_go;
    logic push_in;
    logic push_res;
    logic set_zdiv;
    logic set_unk;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic b_zero;
    logic ib_zero;
    logic div_busy;
    logic out_busy;
  } dp_sts_t;

  // magnitude of a signed word; the most negative value maps to 2^31
  function automatic logic [DATA_W-1:0] mag(input logic [DATA_W-1:0] v);
    mag = v[DATA_W-1] ? (~v + 1'b1) : v;
  endfunction

  // signed result from sign and magnitude, clamped to the Q16.16 range
  function automatic logic [DATA_W-1:0] sat_mag(input logic neg,
                                                input logic [DVD_W-1:0] m);
    logic [DATA_W-1:0] r;
    if (neg) begin
      if (m >= 48'h0000_8000_0000) r = 32'h8000_0000;
      else r = ~m[DATA_W-1:0] + 1'b1;
    end else begin
      if (m > 48'h0000_7FFF_FFFF) r = 32'h7FFF_FFFF;
      else r = m[DATA_W-1:0];
    end
    sat_mag = r;
  endfunction

  // clamp a 33-bit signed sum
  function automatic logic [DATA_W-1:0] sat33(input logic [DATA_W:0] s);
    logic [DATA_W-1:0] r;
    if (s[DATA_W] != s[DATA_W-1]) r = s[DATA_W] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    else r = s[DATA_W-1:0];
    sat33 = r;
  endfunction

endpackage

### rtl/rpn_stack_calculator_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rpn_stack_calculator_top: RPN evaluator over a Q16.16 value stack
// Input stream carries requests, output stream one status item per request.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one item per request; tuser = req_type, tdata = push_value.
//   out_* : one item per request; tdata = popped value (peek_pop, else 0),
//           tuser = flags {unknown, zero_divisor, full, empty, value_valid}.
//   Each request walks the sequencer: push/unknown go from dispatch to
//   output; peek_pop pops and latches B; add/sub/mul/div/mod also pop and
//   latch A, execute and push the result, div/mod first waiting on the
//   divider (one quotient bit per cycle over 48 bits); a rejected divisor
//   skips to output. One request is in flight at a time; the next is taken
//   in the cycle after the result is loaded into the output register.
//   Stack memory is a single-port RAM: each pop and push costs one access.
//   Reset empties the stack (pointer to zero); memory contents are not
//   cleared and need no clearing pass.
//   If the receiver stalls, the result holds in out_tdata/out_tuser and the
//   next request runs up to its hand-off, then waits there.
// ---------------------------------------------------------------------------
module rpn_stack_calculator_top #(
  parameter int STACK_DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] push_value
  input  logic [2:0]  in_tuser,   // [2:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] top_value
  output logic [4:0]  out_tuser   // [0] value_valid, [1] empty_error, [2] full_error,
                                  // [3] zero_divisor_error, [4] unknown_error
);
  import rpn_pkg::*;

  dp_cmd_t cmd;   // sequencer to datapath
  dp_sts_t sts;   // datapath back to sequencer

  rpn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_req    (in_tuser),
    .sts       (sts),
    .cmd       (cmd)
  );

  rpn_dp #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_req     (in_tuser),
    .in_pv      (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

### rtl/rpn_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rpn_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ---------------------------------------------------------------------------
module rpn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/rpn_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rpn_div: restoring unsigned divider
// 48-bit dividend by 32-bit divisor, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module rpn_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [rpn_pkg::DVD_W-1:0]  dividend,
  input  logic [rpn_pkg::DATA_W-1:0] divisor,
  output logic                      busy,
  output logic [rpn_pkg::DVD_W-1:0]  quot,
  output logic [rpn_pkg::DATA_W-1:0] rem
);
  import rpn_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [CNT_W-1:0]  cnt_r;
  logic [DVD_W-1:0]  dvd_r, dvd_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt, dvs_r;
  logic [DATA_W:0]   sh, diff;
  logic              qbit;

  always_comb begin
    sh   = {rem_r, dvd_r[DVD_W-1]};
    diff = sh - {1'b0, dvs_r};
    qbit = (sh >= {1'b0, dvs_r});
    rem_nxt = qbit ? diff[DATA_W-1:0] : sh[DATA_W-1:0];
    dvd_nxt = {dvd_r[DVD_W-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CNT_W'(DVD_W);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (cnt_r != '0) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy = (cnt_r != '0);
  assign quot = dvd_r;
  assign rem  = rem_r;

endmodule

### rtl/rpn_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rpn_dp: calculator datapath
// Stack memory and pointer, operand registers, multiplier, divider, result reg.
// ---------------------------------------------------------------------------
module rpn_dp #(
  parameter int STACK_DEPTH = 128
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rpn_pkg::req_t              in_req,
  input  logic [rpn_pkg::DATA_W-1:0] in_pv,
  input  rpn_pkg::dp_cmd_t           cmd,
  output rpn_pkg::dp_sts_t           sts,
  input  logic                       out_tready,
  output logic                       out_tvalid,
  output logic [rpn_pkg::DATA_W-1:0] out_tdata,
  output logic [rpn_pkg::FLAG_W-1:0] out_tuser
);
  import rpn_pkg::*;

  localparam int AW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SP_W = $clog2(STACK_DEPTH + 1);
  localparam logic [SP_W-1:0] DEPTH_V = SP_W'(STACK_DEPTH);

  req_t              op_r;
  logic [DATA_W-1:0] pv_r, a_r, b_r, rdata, pop_val, res, wdata;
  logic [2*DATA_W-1:0] prod_r;
  logic [SP_W-1:0]   sp_r, sp_dec;
  logic              hit_r, emp_r, full_r, zdiv_r, unk_r;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_data_r;
  logic [FLAG_W-1:0] out_user_r;
  logic              push, has_room, we;
  logic [AW-1:0]     addr;
  logic [DVD_W-1:0]  dvd, quot;
  logic [DATA_W-1:0] dvs, rem, ma, mb;
  logic              div_busy;

  assign pop_val  = hit_r ? rdata : '0;
  assign sp_dec   = sp_r - SP_W'(1);
  assign push     = cmd.push_in | cmd.push_res;
  assign has_room = (sp_r < DEPTH_V);
  assign we       = push & has_room;
  assign addr     = push ? sp_r[AW-1:0] : sp_dec[AW-1:0];
  assign ma       = mag(a_r);
  assign mb       = mag(b_r);

  always_comb begin
    if (op_r == REQ_MOD) begin
      dvd = {{(DVD_W-16){1'b0}}, ma[31:16]};
      dvs = {16'b0, mb[31:16]};
    end else begin
      dvd = {ma, 16'b0};
      dvs = mb;
    end
  end

  always_comb begin
    case (op_r)
      REQ_ADD: res = sat33({a_r[31], a_r} + {b_r[31], b_r});
      REQ_SUB: res = sat33({a_r[31], a_r} - {b_r[31], b_r});
      REQ_MUL: res = sat_mag(a_r[31] ^ b_r[31], prod_r[63:16]);
      REQ_DIV: res = sat_mag(a_r[31] ^ b_r[31], quot);
      REQ_MOD: res = sat_mag(a_r[31], {16'b0, rem[15:0], 16'b0});
      default: res = '0;
    endcase
  end

  assign wdata = cmd.push_in ? pv_r : res;

  rpn_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .addr  (addr),
    .wdata (wdata),
    .rdata (rdata)
  );

  rpn_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_go),
    .dividend (dvd),
    .divisor  (dvs),
    .busy     (div_busy),
    .quot     (quot),
    .rem      (rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r   <= '0;
      hit_r  <= 1'b0;
      emp_r  <= 1'b0;
      full_r <= 1'b0;
      zdiv_r <= 1'b0;
      unk_r  <= 1'b0;
    end else begin
      if (cmd.start) begin
        emp_r  <= 1'b0;
        full_r <= 1'b0;
        zdiv_r <= 1'b0;
        unk_r  <= 1'b0;
      end
      if (cmd.pop) begin
        if (sp_r != '0) begin
          sp_r  <= sp_dec;
          hit_r <= 1'b1;
        end else begin
          hit_r <= 1'b0;
          emp_r <= 1'b1;
        end
      end
      if (push) begin
        if (has_room) sp_r <= sp_r + SP_W'(1);
        else full_r <= 1'b1;
      end
      if (cmd.set_zdiv) zdiv_r <= 1'b1;
      if (cmd.set_unk) unk_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r <= in_req;
      pv_r <= in_pv;
    end
    if (cmd.lat_b) b_r <= pop_val;
    if (cmd.lat_a) a_r <= pop_val;
    if (cmd.mul) prod_r <= ma * mb;
  end

  // result register; freed when the receiver takes the item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= (op_r == REQ_PEEK) ? b_r : '0;
      out_user_r <= {unk_r, zdiv_r, full_r, emp_r, op_r == REQ_PEEK};
    end
  end

  assign sts = '{b_zero:   (pop_val == '0),
                 ib_zero:  ((mag(pop_val) >> 16) == '0),
                 div_busy: div_busy,
                 out_busy: out_valid_r & ~out_tready};
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser    = out_user_r;

endmodule

### rtl/rpn_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rpn_ctrl: calculator sequencer
// Walks each request through pops, arithmetic, push and result hand-off.
// ---------------------------------------------------------------------------
module rpn_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  rpn_pkg::req_t     in_req,
  input  rpn_pkg::dp_sts_t  sts,
  output rpn_pkg::dp_cmd_t  cmd
);
  import rpn_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_POPB = 4'd2;
  localparam logic [3:0] S_LATB = 4'd3;
  localparam logic [3:0] S_POPA = 4'd4;
  localparam logic [3:0] S_LATA = 4'd5;
  localparam logic [3:0] S_EXEC = 4'd6;
  localparam logic [3:0] S_DIVW = 4'd7;
  localparam logic [3:0] S_PUSH = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0] state_r, state_nxt;
  req_t       req_r;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.start = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (req_r)
          REQ_PUSH: begin
            cmd.push_in = 1'b1;
            state_nxt   = S_OUT;
          end
          REQ_UNK: begin
            cmd.set_unk = 1'b1;
            state_nxt   = S_OUT;
          end
          default: state_nxt = S_POPB;
        endcase
      end
      S_POPB: begin
        cmd.pop   = 1'b1;
        state_nxt = S_LATB;
      end
      S_LATB: begin
        cmd.lat_b = 1'b1;
        if (req_r == REQ_PEEK) begin
          state_nxt = S_OUT;
        end else if ((req_r == REQ_DIV && sts.b_zero) ||
                     (req_r == REQ_MOD && sts.ib_zero)) begin
          cmd.set_zdiv = 1'b1;
          state_nxt    = S_OUT;
        end else begin
          state_nxt = S_POPA;
        end
      end
      S_POPA: begin
        cmd.pop   = 1'b1;
        state_nxt = S_LATA;
      end
      S_LATA: begin
        cmd.lat_a = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        case (req_r) inside
          REQ_MUL: begin
            cmd.mul   = 1'b1;
            state_nxt = S_PUSH;
          end
          REQ_DIV, REQ_MOD: begin
            cmd.div_go = 1'b1;
            state_nxt  = S_DIVW;
          end
          default: state_nxt = S_PUSH;
        endcase
      end
      S_DIVW: begin
        if (!sts.div_busy) state_nxt = S_PUSH;
      end
      S_PUSH: begin
        cmd.push_res = 1'b1;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) req_r <= in_req;
  end

`include "assert_macros.svh"
  `RPN_ASSERT(a_idle_div_quiet, in_tready |-> !sts.div_busy, "divider busy while idle")
  `RPN_ASSERT(a_one_stack_op, $onehot0({cmd.pop, cmd.push_in, cmd.push_res}), "stack port clash")
  `RPN_ASSERT(a_load_free, cmd.out_load |-> !sts.out_busy, "result overwritten")
  `RPN_ASSERT_RST(a_reset_idle, !rst_n |=> state_r == S_IDLE, "not idle after reset")

endmodule
